// ===== hdl/aes_rr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES reduced-round package
// Shared types, register indexes, the S-box and the round and key-step
// functions of the reduced-round AES-128 encryptor.
// ----------------------------------------------------------------------------
package aes_rr_pkg;

  typedef logic [127:0] block_t;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROUND_COUNT = 2'd2;

  localparam int unsigned RoundCountW     = 5;
  localparam logic [RoundCountW-1:0] RoundCountReset = 5'd10;
  localparam logic [7:0] GfPoly   = 8'h1b;
  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gmul2(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One output column: SubBytes and ShiftRows, then MixColumns when mix is set.
  function automatic logic [31:0] column(input logic [31:0] w0, input logic [31:0] w1,
                                         input logic [31:0] w2, input logic [31:0] w3,
                                         input logic mix);
    logic [7:0] a0, a1, a2, a3, s;
    a0 = SBOX[w0[31:24]];
    a1 = SBOX[w1[23:16]];
    a2 = SBOX[w2[15:8]];
    a3 = SBOX[w3[7:0]];
    s  = a0 ^ a1 ^ a2 ^ a3;
    if (mix) begin
      return {a0 ^ s ^ gmul2(a0 ^ a1), a1 ^ s ^ gmul2(a1 ^ a2),
              a2 ^ s ^ gmul2(a2 ^ a3), a3 ^ s ^ gmul2(a3 ^ a0)};
    end
    return {a0, a1, a2, a3};
  endfunction

  // One round without the key addition.
  function automatic block_t aes_round(input block_t st, input logic mix);
    logic [31:0] s0, s1, s2, s3;
    s0 = st[127:96];
    s1 = st[95:64];
    s2 = st[63:32];
    s3 = st[31:0];
    return {column(s0, s1, s2, s3, mix), column(s1, s2, s3, s0, mix),
            column(s2, s3, s0, s1, mix), column(s3, s0, s1, s2, mix)};
  endfunction

  // Next round key from the previous one.
  function automatic block_t key_step(input block_t w, input logic [7:0] rcon);
    logic [31:0] t, n0, n1, n2, n3;
    t  = sub_word({w[23:0], w[31:24]}) ^ {rcon, 24'h0};
    n0 = w[127:96] ^ t;
    n1 = w[95:64] ^ n0;
    n2 = w[63:32] ^ n1;
    n3 = w[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_rr_intf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES reduced-round channel interfaces
// Valid/ready channels for plaintext requests and ciphertext results.
// ----------------------------------------------------------------------------
interface aes_rr_plain_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

interface aes_rr_cipher_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes128_reduced_round_encrypt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 reduced-round encryptor
// Pipelined AES-128 encryption with a configurable round count and an
// on-chip key schedule that is expanded after reset and after each key write.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries                         Handshake
//  in_i      sink       plain_high, plain_low           valid/ready
//  out_o     source     cipher_high, cipher_low         valid/ready
//  cfg       sink       cfg_idx_i, cfg_wdata_i          cfg_we_i, always taken
//
// One block enters per cycle while the pipeline moves and no key expansion
// runs. Every round has its own pipeline stage after stage 0, and unused
// rounds pass the state through. One shared key-step unit makes one round
// key per cycle; while it runs (after reset and after each key write)
// in_i.ready stays low. When the output stage holds a result that is not
// taken, the whole pipeline holds.
// ----------------------------------------------------------------------------
module aes128_reduced_round_encrypt
  import aes_rr_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  aes_rr_plain_if.sink             in_i,
  aes_rr_cipher_if.source          out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [63:0]         cfg_wdata_i
);

  localparam int unsigned NrW = $clog2(MAX_ROUNDS + 1);

  // Configuration registers.
  logic [63:0]            key_high_q, key_low_q;
  logic [RoundCountW-1:0] round_count_q;
  logic                   key_wr;

  assign key_wr = cfg_we_i && (cfg_idx_i == CFG_KEY_HIGH || cfg_idx_i == CFG_KEY_LOW);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q    <= '0;
      key_low_q     <= '0;
      round_count_q <= RoundCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_HIGH:    key_high_q    <= cfg_wdata_i;
        CFG_KEY_LOW:     key_low_q     <= cfg_wdata_i;
        CFG_ROUND_COUNT: round_count_q <= cfg_wdata_i[RoundCountW-1:0];
        default: ;
      endcase
    end
  end

  // Key schedule: during an expansion a working key register steps once per
  // cycle and each new round key is written to the register of its own round
  // stage. Round key 0 is the key itself.
  block_t          work_q;
  logic [7:0]      rcon_q;
  logic [NrW-1:0]  exp_cnt_q;
  logic            busy_q;
  block_t          next_key;
  block_t          rk_q [1:MAX_ROUNDS];

  assign next_key = key_step(work_q, rcon_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q    <= '0;
      rcon_q    <= RconInit;
      exp_cnt_q <= NrW'(1);
      busy_q    <= 1'b1;
    end else if (key_wr) begin
      work_q    <= (cfg_idx_i == CFG_KEY_HIGH) ? {cfg_wdata_i, key_low_q}
                                               : {key_high_q, cfg_wdata_i};
      rcon_q    <= RconInit;
      exp_cnt_q <= NrW'(1);
      busy_q    <= 1'b1;
    end else if (busy_q) begin
      work_q    <= next_key;
      rcon_q    <= gmul2(rcon_q);
      exp_cnt_q <= exp_cnt_q + NrW'(1);
      busy_q    <= (exp_cnt_q != NrW'(MAX_ROUNDS));
    end
  end

  for (genvar k = 1; k <= MAX_ROUNDS; k++) begin : g_rk
    always_ff @(posedge clk_i) begin
      if (busy_q && !key_wr && exp_cnt_q == NrW'(k)) begin
        rk_q[k] <= next_key;
      end
    end
  end

  // Effective round count: zero counts as one, anything above the maximum
  // saturates.
  logic [NrW-1:0] nr_in;
  always_comb begin
    priority if ({1'b0, round_count_q} > (RoundCountW + 1)'(MAX_ROUNDS)) begin
      nr_in = NrW'(MAX_ROUNDS);
    end else if (round_count_q == '0) begin
      nr_in = NrW'(1);
    end else begin
      nr_in = NrW'(round_count_q);
    end
  end

  // Pipeline: stage 0 adds round key 0, stage r does round r when the
  // request needs it and passes the state through otherwise.
  block_t          st_q  [0:MAX_ROUNDS];
  logic [NrW-1:0]  nr_q  [0:MAX_ROUNDS];
  logic            vld_q [0:MAX_ROUNDS];
  logic            adv;

  assign adv         = !vld_q[MAX_ROUNDS] || out_o.ready;
  assign in_i.ready  = adv && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_i.valid && !busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0] <= {in_i.plain_high, in_i.plain_low} ^ {key_high_q, key_low_q};
      nr_q[0] <= nr_in;
    end
  end

  for (genvar r = 1; r <= MAX_ROUNDS; r++) begin : g_round
    block_t st_d;
    always_comb begin
      if (nr_q[r-1] >= NrW'(r)) begin
        st_d = aes_round(st_q[r-1], nr_q[r-1] != NrW'(r)) ^ rk_q[r];
      end else begin
        st_d = st_q[r-1];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r] <= 1'b0;
      end else if (adv) begin
        vld_q[r] <= vld_q[r-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[r] <= st_d;
        nr_q[r] <= nr_q[r-1];
      end
    end
  end

  assign out_o.valid       = vld_q[MAX_ROUNDS];
  assign out_o.cipher_high = st_q[MAX_ROUNDS][127:64];
  assign out_o.cipher_low  = st_q[MAX_ROUNDS][63:0];

endmodule
`default_nettype wire

// ===== hdl/aes_rr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// AES reduced-round port checker
// Watches the encryptor's ports for handshake and flow-control slips.
// ----------------------------------------------------------------------------
module aes_rr_checker
  import aes_rr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [127:0]       out_data,
  input wire logic               cfg_we,
  input wire logic [CfgIdxW-1:0] cfg_idx
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // A full output stage that is not drained holds back new requests.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while pipeline stalled");

  // A key write starts a schedule expansion, which blocks requests.
  a_key_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && (cfg_idx == CFG_KEY_HIGH || cfg_idx == CFG_KEY_LOW) |=> !in_ready)
    else $error("request taken during key expansion");

endmodule

bind aes128_reduced_round_encrypt aes_rr_checker u_aes_rr_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  ({out_o.cipher_high, out_o.cipher_low}),
  .cfg_we    (cfg_we_i),
  .cfg_idx   (cfg_idx_i)
);
`default_nettype wire
